### src/sint_pkg.sv
// Shared types and constants for the segment intersection pipeline.
// Depends on nothing; every other source file refers to it by scoped names.
package sint_pkg;

    // Coordinate width and the exact widths of every intermediate value.
    localparam int COORD_BITS = 24;
    localparam int AW  = COORD_BITS + 1;          // a = dy, b = -dx
    localparam int PW  = 2 * COORD_BITS;          // x * y products
    localparam int CW  = 2 * COORD_BITS + 1;      // c = x2*y1 - x1*y2
    localparam int CHW = CW - COORD_BITS;         // signed high part of c
    localparam int MW  = AW + CHW;                // a or b times a half of c
    localparam int DPW = 2 * AW;                  // a * b products
    localparam int DW  = 2 * COORD_BITS + 3;      // determinant
    localparam int NW  = 3 * COORD_BITS + 3;      // Cramer numerators
    localparam int QB  = COORD_BITS + 1;          // quotient bits developed
    localparam int LPW = AW + COORD_BITS;         // a1 * x products
    localparam int LW  = 2 * COORD_BITS + 3;      // on-line residual
    localparam int IN_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // The eight input coordinates of one query.
    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t x3;
        coord_t y3;
        coord_t x4;
        coord_t y4;
    } pts_t;

    // First-line data that rides along for the on-line test.
    typedef struct packed {
        logic signed [AW-1:0] a1;
        logic signed [AW-1:0] b1;
        logic signed [CW-1:0] c1;
        coord_t               xlo;
        coord_t               xhi;
        coord_t               ylo;
        coord_t               yhi;
    } side_t;

    // Working state of one restoring division.
    typedef struct packed {
        logic [QB-1:0] quo;
        logic [DW-1:0] rem;
        logic [QB-1:0] nlow;
        logic [DW-1:0] dmag;
        logic          neg;
        logic          ovf;
    } quot_t;

    // One result transaction.
    typedef struct packed {
        logic   parallel;
        coord_t cross_x;
        coord_t cross_y;
        logic   on_first_segment;
    } result_t;

endpackage

### src/sint_front.sv
// Front end: line coefficients, determinant and Cramer numerators, five stages.
// Depends on sint_pkg.
module sint_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  sint_pkg::pts_t                  pts,
    output logic                            out_valid,
    output logic signed [sint_pkg::NW-1:0]  num_x,
    output logic signed [sint_pkg::NW-1:0]  num_y,
    output logic signed [sint_pkg::DW-1:0]  det,
    output sint_pkg::side_t                 side
);

    logic [4:0] vld_reg;

    // Stage 1: deltas, corner products and the bounding box.
    logic signed [sint_pkg::AW-1:0] s1_a1_reg, s1_b1_reg, s1_a2_reg, s1_b2_reg;
    logic signed [sint_pkg::AW-1:0] s1_a1_next, s1_b1_next, s1_a2_next, s1_b2_next;
    logic signed [sint_pkg::PW-1:0] s1_p21_reg, s1_p12_reg, s1_p43_reg, s1_p34_reg;
    logic signed [sint_pkg::PW-1:0] s1_p21_next, s1_p12_next, s1_p43_next, s1_p34_next;
    sint_pkg::coord_t s1_xlo_reg, s1_xhi_reg, s1_ylo_reg, s1_yhi_reg;

    // Stage 2: c terms and determinant products.
    logic signed [sint_pkg::AW-1:0]  s2_a2_reg, s2_b2_reg;
    logic signed [sint_pkg::CW-1:0]  s2_c2_reg, s2_c2_next, s2_c1_next;
    logic signed [sint_pkg::DPW-1:0] s2_q1_reg, s2_q2_reg, s2_q1_next, s2_q2_next;
    sint_pkg::side_t                 s2_side_reg, s2_side_next;

    // Stage 3: determinant and split numerator products.
    logic signed [sint_pkg::DW-1:0] s3_det_reg, s3_det_next;
    logic signed [sint_pkg::MW-1:0] s3_b1c2h_reg, s3_b1c2l_reg, s3_b2c1h_reg, s3_b2c1l_reg;
    logic signed [sint_pkg::MW-1:0] s3_a2c1h_reg, s3_a2c1l_reg, s3_a1c2h_reg, s3_a1c2l_reg;
    logic signed [sint_pkg::CHW-1:0] c1_hi, c2_hi;
    logic signed [sint_pkg::CHW-1:0] c1_lo, c2_lo;
    sint_pkg::side_t                 s3_side_reg;

    // Stage 4: whole numerator products.
    logic signed [sint_pkg::NW-1:0] s4_b1c2_reg, s4_b2c1_reg, s4_a2c1_reg, s4_a1c2_reg;
    logic signed [sint_pkg::NW-1:0] s4_b1c2_next, s4_b2c1_next, s4_a2c1_next, s4_a1c2_next;
    logic signed [sint_pkg::DW-1:0] s4_det_reg;
    sint_pkg::side_t                s4_side_reg;

    // Stage 5: numerators.
    logic signed [sint_pkg::NW-1:0] s5_nx_reg, s5_ny_reg;
    logic signed [sint_pkg::DW-1:0] s5_det_reg;
    sint_pkg::side_t                s5_side_reg;

    // Valid bits advance with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Stage 1 arithmetic.
    assign s1_a1_next  = pts.y2 - pts.y1;
    assign s1_b1_next  = pts.x1 - pts.x2;
    assign s1_a2_next  = pts.y4 - pts.y3;
    assign s1_b2_next  = pts.x3 - pts.x4;
    assign s1_p21_next = pts.x2 * pts.y1;
    assign s1_p12_next = pts.x1 * pts.y2;
    assign s1_p43_next = pts.x4 * pts.y3;
    assign s1_p34_next = pts.x3 * pts.y4;

    // Stage 2 arithmetic.
    assign s2_c1_next = s1_p21_reg - s1_p12_reg;
    assign s2_c2_next = s1_p43_reg - s1_p34_reg;
    assign s2_q1_next = s1_a1_reg * s1_b2_reg;
    assign s2_q2_next = s1_a2_reg * s1_b1_reg;

    always_comb
    begin
        s2_side_next.a1  = s1_a1_reg;
        s2_side_next.b1  = s1_b1_reg;
        s2_side_next.c1  = s2_c1_next;
        s2_side_next.xlo = s1_xlo_reg;
        s2_side_next.xhi = s1_xhi_reg;
        s2_side_next.ylo = s1_ylo_reg;
        s2_side_next.yhi = s1_yhi_reg;
    end

    // Stage 3: c is split into a signed high half and an unsigned low half.
    assign s3_det_next = s2_q1_reg - s2_q2_reg;
    assign c1_hi = $signed(s2_side_reg.c1[sint_pkg::CW-1:sint_pkg::COORD_BITS]);
    assign c2_hi = $signed(s2_c2_reg[sint_pkg::CW-1:sint_pkg::COORD_BITS]);
    assign c1_lo = $signed({1'b0, s2_side_reg.c1[sint_pkg::COORD_BITS-1:0]});
    assign c2_lo = $signed({1'b0, s2_c2_reg[sint_pkg::COORD_BITS-1:0]});

    // Stage 4: recombine the halves.
    assign s4_b1c2_next = (s3_b1c2h_reg <<< sint_pkg::COORD_BITS) + s3_b1c2l_reg;
    assign s4_b2c1_next = (s3_b2c1h_reg <<< sint_pkg::COORD_BITS) + s3_b2c1l_reg;
    assign s4_a2c1_next = (s3_a2c1h_reg <<< sint_pkg::COORD_BITS) + s3_a2c1l_reg;
    assign s4_a1c2_next = (s3_a1c2h_reg <<< sint_pkg::COORD_BITS) + s3_a1c2l_reg;

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_a1_reg  <= s1_a1_next;
            s1_b1_reg  <= s1_b1_next;
            s1_a2_reg  <= s1_a2_next;
            s1_b2_reg  <= s1_b2_next;
            s1_p21_reg <= s1_p21_next;
            s1_p12_reg <= s1_p12_next;
            s1_p43_reg <= s1_p43_next;
            s1_p34_reg <= s1_p34_next;
            s1_xlo_reg <= (pts.x1 < pts.x2) ? pts.x1 : pts.x2;
            s1_xhi_reg <= (pts.x1 < pts.x2) ? pts.x2 : pts.x1;
            s1_ylo_reg <= (pts.y1 < pts.y2) ? pts.y1 : pts.y2;
            s1_yhi_reg <= (pts.y1 < pts.y2) ? pts.y2 : pts.y1;

            s2_a2_reg   <= s1_a2_reg;
            s2_b2_reg   <= s1_b2_reg;
            s2_c2_reg   <= s2_c2_next;
            s2_q1_reg   <= s2_q1_next;
            s2_q2_reg   <= s2_q2_next;
            s2_side_reg <= s2_side_next;

            s3_det_reg   <= s3_det_next;
            s3_b1c2h_reg <= s2_side_reg.b1 * c2_hi;
            s3_b1c2l_reg <= s2_side_reg.b1 * c2_lo;
            s3_b2c1h_reg <= s2_b2_reg * c1_hi;
            s3_b2c1l_reg <= s2_b2_reg * c1_lo;
            s3_a2c1h_reg <= s2_a2_reg * c1_hi;
            s3_a2c1l_reg <= s2_a2_reg * c1_lo;
            s3_a1c2h_reg <= s2_side_reg.a1 * c2_hi;
            s3_a1c2l_reg <= s2_side_reg.a1 * c2_lo;
            s3_side_reg  <= s2_side_reg;

            s4_b1c2_reg <= s4_b1c2_next;
            s4_b2c1_reg <= s4_b2c1_next;
            s4_a2c1_reg <= s4_a2c1_next;
            s4_a1c2_reg <= s4_a1c2_next;
            s4_det_reg  <= s3_det_reg;
            s4_side_reg <= s3_side_reg;

            s5_nx_reg   <= s4_b1c2_reg - s4_b2c1_reg;
            s5_ny_reg   <= s4_a2c1_reg - s4_a1c2_reg;
            s5_det_reg  <= s4_det_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign num_x     = s5_nx_reg;
    assign num_y     = s5_ny_reg;
    assign det       = s5_det_reg;
    assign side      = s5_side_reg;

endmodule

### src/sint_div.sv
// Pipelined restoring divider for both crossing coordinates, one quotient bit
// per stage, preceded by a magnitude stage and an overflow check stage.
// Depends on sint_pkg.
module sint_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [sint_pkg::NW-1:0]  num_x,
    input  logic signed [sint_pkg::NW-1:0]  num_y,
    input  logic signed [sint_pkg::DW-1:0]  det,
    input  sint_pkg::side_t                 side_in,
    output logic                            out_valid,
    output sint_pkg::quot_t                 quo_x,
    output sint_pkg::quot_t                 quo_y,
    output logic                            par,
    output sint_pkg::side_t                 side_out
);

    // Magnitude stage.
    logic                          mag_vld_reg;
    logic [sint_pkg::NW-1:0]       nabs_x_reg, nabs_y_reg;
    logic [sint_pkg::DW-1:0]       dmag_reg;
    logic                          neg_x_reg, neg_y_reg, mag_par_reg;
    sint_pkg::side_t               mag_side_reg;

    // Division stages; index 0 holds the initial partial remainder.
    logic [sint_pkg::QB:0]         vld_reg;
    sint_pkg::quot_t               qx_reg   [0:sint_pkg::QB];
    sint_pkg::quot_t               qy_reg   [0:sint_pkg::QB];
    logic                          par_reg  [0:sint_pkg::QB];
    sint_pkg::side_t               side_reg [0:sint_pkg::QB];
    sint_pkg::quot_t               init_x, init_y;

    // One restoring step: shift in a numerator bit, subtract when it fits.
    function automatic sint_pkg::quot_t div_step(input sint_pkg::quot_t cur,
                                                 input logic bitin);
        logic [sint_pkg::DW:0] trial;
        sint_pkg::quot_t       nxt;
        nxt   = cur;
        trial = {cur.rem, bitin} - {1'b0, cur.dmag};
        if (!trial[sint_pkg::DW])
        begin
            nxt.rem = trial[sint_pkg::DW-1:0];
            nxt.quo = {cur.quo[sint_pkg::QB-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = {cur.rem[sint_pkg::DW-2:0], bitin};
            nxt.quo = {cur.quo[sint_pkg::QB-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Initial remainder is the numerator above the quotient bits; when that
    // already reaches the divisor the quotient cannot fit and will saturate.
    function automatic sint_pkg::quot_t div_init(input logic [sint_pkg::NW-1:0] nabs,
                                                 input logic [sint_pkg::DW-1:0] dmag,
                                                 input logic neg);
        sint_pkg::quot_t st;
        st.quo  = '0;
        st.rem  = {1'b0, nabs[sint_pkg::NW-1:sint_pkg::QB]};
        st.nlow = nabs[sint_pkg::QB-1:0];
        st.dmag = dmag;
        st.neg  = neg;
        st.ovf  = ({1'b0, nabs[sint_pkg::NW-1:sint_pkg::QB]} >= dmag);
        return st;
    endfunction

    assign init_x = div_init(nabs_x_reg, dmag_reg, neg_x_reg);
    assign init_y = div_init(nabs_y_reg, dmag_reg, neg_y_reg);

    // Valid bits for the whole divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else if (ce)
        begin
            mag_vld_reg <= in_valid;
            vld_reg     <= {vld_reg[sint_pkg::QB-1:0], mag_vld_reg};
        end
    end

    // Magnitudes, signs and the parallel flag.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            nabs_x_reg   <= num_x[sint_pkg::NW-1] ? -num_x : num_x;
            nabs_y_reg   <= num_y[sint_pkg::NW-1] ? -num_y : num_y;
            dmag_reg     <= det[sint_pkg::DW-1] ? -det : det;
            neg_x_reg    <= num_x[sint_pkg::NW-1] ^ det[sint_pkg::DW-1];
            neg_y_reg    <= num_y[sint_pkg::NW-1] ^ det[sint_pkg::DW-1];
            mag_par_reg  <= (det == '0);
            mag_side_reg <= side_in;

            qx_reg[0]   <= init_x;
            qy_reg[0]   <= init_y;
            par_reg[0]  <= mag_par_reg;
            side_reg[0] <= mag_side_reg;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < sint_pkg::QB; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                qx_reg[k+1]   <= div_step(qx_reg[k], qx_reg[k].nlow[sint_pkg::QB-1-k]);
                qy_reg[k+1]   <= div_step(qy_reg[k], qy_reg[k].nlow[sint_pkg::QB-1-k]);
                par_reg[k+1]  <= par_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[sint_pkg::QB];
    assign quo_x     = qx_reg[sint_pkg::QB];
    assign quo_y     = qy_reg[sint_pkg::QB];
    assign par       = par_reg[sint_pkg::QB];
    assign side_out  = side_reg[sint_pkg::QB];

endmodule

### src/sint_back.sv
// Back end: rounding, saturation and the on-segment test, four stages.
// Depends on sint_pkg.
module sint_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  sint_pkg::quot_t   quo_x,
    input  sint_pkg::quot_t   quo_y,
    input  logic              par,
    input  sint_pkg::side_t   side,
    output logic              out_valid,
    output sint_pkg::result_t result
);

    logic [3:0] vld_reg;

    // Stage 1: rounded magnitudes.
    logic [sint_pkg::QB:0]  r1_qx_reg, r1_qy_reg, r1_qx_next, r1_qy_next;
    logic                   r1_negx_reg, r1_negy_reg, r1_ovfx_reg, r1_ovfy_reg;
    logic                   r1_par_reg;
    sint_pkg::side_t        r1_side_reg;

    // Stage 2: saturated coordinates.
    sint_pkg::coord_t       r2_px_reg, r2_py_reg, r2_px_next, r2_py_next;
    logic                   r2_par_reg;
    sint_pkg::side_t        r2_side_reg;

    // Stage 3: on-line products and the box test.
    logic signed [sint_pkg::LPW-1:0] r3_ax_reg, r3_by_reg;
    logic signed [sint_pkg::CW-1:0]  r3_c1_reg;
    sint_pkg::coord_t       r3_px_reg, r3_py_reg;
    logic                   r3_inbox_reg, r3_par_reg;

    // Stage 4: final result.
    logic signed [sint_pkg::LW-1:0]  resid;
    sint_pkg::result_t      r4_res_reg, r4_res_next;

    // Round half away from zero: add one when twice the remainder reaches the divisor.
    function automatic logic [sint_pkg::QB:0] round_mag(input sint_pkg::quot_t q);
        logic up;
        up = ({q.rem, 1'b0} >= {1'b0, q.dmag});
        return {1'b0, q.quo} + {{sint_pkg::QB{1'b0}}, up};
    endfunction

    // Apply the sign and clamp to the coordinate range.
    function automatic sint_pkg::coord_t sat(input logic [sint_pkg::QB:0] qr,
                                             input logic neg,
                                             input logic ovf);
        logic [sint_pkg::QB:0] half;
        sint_pkg::coord_t      res;
        half = {{sint_pkg::QB{1'b0}}, 1'b1} << (sint_pkg::COORD_BITS - 1);
        if (neg)
        begin
            if (ovf || qr >= half)
                res = sint_pkg::COORD_MIN;
            else
                res = -$signed(qr[sint_pkg::COORD_BITS-1:0]);
        end
        else
        begin
            if (ovf || qr >= half)
                res = sint_pkg::COORD_MAX;
            else
                res = $signed(qr[sint_pkg::COORD_BITS-1:0]);
        end
        return res;
    endfunction

    assign r1_qx_next = round_mag(quo_x);
    assign r1_qy_next = round_mag(quo_y);
    assign r2_px_next = r1_par_reg ? '0 : sat(r1_qx_reg, r1_negx_reg, r1_ovfx_reg);
    assign r2_py_next = r1_par_reg ? '0 : sat(r1_qy_reg, r1_negy_reg, r1_ovfy_reg);

    // Residual of the first line's equation at the rounded point.
    assign resid = r3_ax_reg + r3_by_reg + r3_c1_reg;

    always_comb
    begin
        r4_res_next.parallel         = r3_par_reg;
        r4_res_next.cross_x          = r3_px_reg;
        r4_res_next.cross_y          = r3_py_reg;
        r4_res_next.on_first_segment = !r3_par_reg && r3_inbox_reg && (resid == '0);
    end

    // Valid bits advance with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r1_qx_reg   <= r1_qx_next;
            r1_qy_reg   <= r1_qy_next;
            r1_negx_reg <= quo_x.neg;
            r1_negy_reg <= quo_y.neg;
            r1_ovfx_reg <= quo_x.ovf;
            r1_ovfy_reg <= quo_y.ovf;
            r1_par_reg  <= par;
            r1_side_reg <= side;

            r2_px_reg   <= r2_px_next;
            r2_py_reg   <= r2_py_next;
            r2_par_reg  <= r1_par_reg;
            r2_side_reg <= r1_side_reg;

            r3_ax_reg    <= r2_side_reg.a1 * r2_px_reg;
            r3_by_reg    <= r2_side_reg.b1 * r2_py_reg;
            r3_c1_reg    <= r2_side_reg.c1;
            r3_px_reg    <= r2_px_reg;
            r3_py_reg    <= r2_py_reg;
            r3_par_reg   <= r2_par_reg;
            r3_inbox_reg <= (r2_px_reg >= r2_side_reg.xlo) && (r2_px_reg <= r2_side_reg.xhi)
                         && (r2_py_reg >= r2_side_reg.ylo) && (r2_py_reg <= r2_side_reg.yhi);

            r4_res_reg <= r4_res_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign result    = r4_res_reg;

endmodule

### src/segment_intersection.sv
// Pipeline: on its way to m_tvalid an accepted input transaction passes five
// front stages, 27 divider stages (a magnitude stage, a setup stage and 25 quotient
// bits), four back stages and the output register. Throughput: one transaction per
// cycle while the skid entry is free; a two-entry output buffer absorbs a stall.
// Reset: rst_n clears all valid bits and the output buffer; payload is not reset.
// Depends on sint_pkg, sint_front, sint_div and sint_back.
module segment_intersection (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [sint_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cross_x, cross_y, on_first_segment, zero padding
    output logic [sint_pkg::OUT_W-1:0]   m_tdata,
    // parallel
    output logic                         m_tuser
);

    logic                      ce;
    sint_pkg::pts_t            pts;
    logic                      fr_valid, dv_valid, bk_valid;
    logic signed [sint_pkg::NW-1:0] fr_num_x, fr_num_y;
    logic signed [sint_pkg::DW-1:0] fr_det;
    sint_pkg::side_t           fr_side, dv_side;
    sint_pkg::quot_t           dv_qx, dv_qy;
    logic                      dv_par;
    sint_pkg::result_t         bk_res;

    logic                      out_valid_reg, skid_valid_reg;
    sint_pkg::result_t         out_res_reg, skid_res_reg;
    logic                      take, out_free;

    // Input field unpacking.
    localparam int N = sint_pkg::COORD_BITS;
    assign pts.x1 = s_tdata[0*N +: N];
    assign pts.y1 = s_tdata[1*N +: N];
    assign pts.x2 = s_tdata[2*N +: N];
    assign pts.y2 = s_tdata[3*N +: N];
    assign pts.x3 = s_tdata[4*N +: N];
    assign pts.y3 = s_tdata[5*N +: N];
    assign pts.x4 = s_tdata[6*N +: N];
    assign pts.y4 = s_tdata[7*N +: N];

    // The pipeline moves whenever the skid entry is free.
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    sint_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .pts       (pts),
        .out_valid (fr_valid),
        .num_x     (fr_num_x),
        .num_y     (fr_num_y),
        .det       (fr_det),
        .side      (fr_side)
    );

    sint_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (fr_valid),
        .num_x     (fr_num_x),
        .num_y     (fr_num_y),
        .det       (fr_det),
        .side_in   (fr_side),
        .out_valid (dv_valid),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .par       (dv_par),
        .side_out  (dv_side)
    );

    sint_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (dv_valid),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .par       (dv_par),
        .side      (dv_side),
        .out_valid (bk_valid),
        .result    (bk_res)
    );

    // A result leaves the pipeline on every enabled cycle that it is valid.
    assign take     = ce && bk_valid;
    assign out_free = !out_valid_reg || m_tready;

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : bk_res;
        end
        else if (take)
        begin
            skid_res_reg <= bk_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.parallel;
    assign m_tdata  = {{(sint_pkg::OUT_W - 2*N - 1){1'b0}},
                       out_res_reg.on_first_segment,
                       out_res_reg.cross_y,
                       out_res_reg.cross_x};

endmodule

### src/sint_checker.sv
// Port-level checks for segment_intersection, attached with a bind statement.
// Depends on sint_pkg and segment_intersection.
module sint_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [sint_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);

    // A stalled result transaction stays valid.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result transaction keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Parallel lines give a zero point and no segment hit.
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("parallel result carries a nonzero point");

    // The input side only stalls when a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // After a drain with input offered, the input side stalls only while a result is pending.
    a_no_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && s_tvalid |=> s_tready || m_tvalid)
        else $error("input stalled after a drain with nothing pending");

endmodule

bind segment_intersection sint_checker u_sint_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/segment_intersection_test.sv
// Self-checking testbench for the segment intersection pipeline.
// Depends on sint_pkg and segment_intersection; drives random and directed queries.
`timescale 1ns / 100ps

module segment_intersection_test;

    localparam int LATENCY = 36;

    // Expected crossing for one query.
    typedef struct {
        logic             parallel;
        sint_pkg::coord_t cross_x;
        sint_pkg::coord_t cross_y;
        logic             on_first;
    } crossing_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sint_pkg::IN_W-1:0]     s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sint_pkg::OUT_W-1:0]    m_tdata;
    logic                          m_tuser;

    crossing_t expected_crossings[$];
    int unsigned errors;
    int unsigned queries_sent;
    int unsigned crossings_checked;
    int unsigned parallel_seen;
    int unsigned on_segment_seen;
    logic        sink_stall_enable;
    int unsigned sink_wait;

    segment_intersection uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Signed division of exact numerators, rounded half away from zero, saturated.
    function automatic sint_pkg::coord_t round_div_sat(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic signed [127:0] n_mag;
        logic signed [127:0] d_mag;
        logic signed [127:0] quo;
        logic signed [127:0] rem;
        logic                neg;
        neg   = (num < 0) != (den < 0);
        n_mag = (num < 0) ? -num : num;
        d_mag = (den < 0) ? -den : den;
        quo   = n_mag / d_mag;
        rem   = n_mag % d_mag;
        if (2 * rem >= d_mag)
            quo = quo + 1;
        if (neg)
        begin
            if (quo >= (128'sd1 <<< (sint_pkg::COORD_BITS - 1)))
                return sint_pkg::COORD_MIN;
            return sint_pkg::coord_t'(-quo);
        end
        if (quo > 128'(sint_pkg::COORD_MAX))
            return sint_pkg::COORD_MAX;
        return sint_pkg::coord_t'(quo);
    endfunction

    // Cramer's-rule crossing of the two lines, and whether it is on the first segment.
    function automatic crossing_t predict_crossing(sint_pkg::pts_t p);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] a1, b1, c1, a2, b2, c2, det, px, py;
        crossing_t           r;
        x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
        x3 = p.x3; y3 = p.y3; x4 = p.x4; y4 = p.y4;
        a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
        a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
        det = a1 * b2 - a2 * b1;
        r.parallel = 1'b0;
        r.cross_x  = '0;
        r.cross_y  = '0;
        r.on_first = 1'b0;
        if (det == 0)
        begin
            r.parallel = 1'b1;
            return r;
        end
        r.cross_x = round_div_sat(b1 * c2 - b2 * c1, det);
        r.cross_y = round_div_sat(a2 * c1 - a1 * c2, det);
        px = r.cross_x;
        py = r.cross_y;
        if (a1 * px + b1 * py + c1 == 0)
            r.on_first = (px >= ((x1 < x2) ? x1 : x2)) && (px <= ((x1 < x2) ? x2 : x1))
                      && (py >= ((y1 < y2) ? y1 : y2)) && (py <= ((y1 < y2) ? y2 : y1));
        return r;
    endfunction

    // Sends a query after a random gap, if allowed, and records its expected crossing.
    // The valid line stays high after acceptance; the next gap or a drain lowers it.
    task automatic send_query(sint_pkg::pts_t p, bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? $urandom_range(0, 15) : 0;
        if (allow_gap && $urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.y4, p.x4, p.y3, p.x3, p.y2, p.x2, p.y1, p.x1};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_crossings.push_back(predict_crossing(p));
        queries_sent++;
    endtask

    function automatic sint_pkg::pts_t make_pts(int x1, int y1, int x2, int y2,
                                                int x3, int y3, int x4, int y4);
        sint_pkg::pts_t p;
        p.x1 = sint_pkg::coord_t'(x1); p.y1 = sint_pkg::coord_t'(y1);
        p.x2 = sint_pkg::coord_t'(x2); p.y2 = sint_pkg::coord_t'(y2);
        p.x3 = sint_pkg::coord_t'(x3); p.y3 = sint_pkg::coord_t'(y3);
        p.x4 = sint_pkg::coord_t'(x4); p.y4 = sint_pkg::coord_t'(y4);
        return p;
    endfunction

    // Draws a coordinate: mostly small, sometimes near or at the extremes.
    function automatic sint_pkg::coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return sint_pkg::coord_t'($urandom);
            1: return ($urandom_range(0, 1))
                      ? sint_pkg::COORD_MAX - sint_pkg::coord_t'($urandom_range(0, 3))
                      : sint_pkg::COORD_MIN + sint_pkg::coord_t'($urandom_range(0, 3));
            2: return sint_pkg::coord_t'(int'($urandom_range(0, 2000)) - 1000);
            default: return sint_pkg::coord_t'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Idles the input and waits until every expected crossing has been returned.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_crossings.size() != 0)
            @(posedge clk);
    endtask

    // Directed corners: parallel, degenerate, extremes, rounding and saturation.
    task automatic test_directed();
        send_query(make_pts(0, 0, 10, 10, 0, 10, 10, 0));
        send_query(make_pts(0, 0, 10, 0, 0, 5, 10, 5));
        send_query(make_pts(3, 3, 3, 3, 0, 0, 5, 7));
        send_query(make_pts(0, 0, 4, 4, 1, 1, 9, 9));
        send_query(make_pts(0, 0, 3, 1, 0, 1, 1, 0));
        send_query(make_pts(0, 0, 2, 1, 1, 0, 1, 5));
        send_query(make_pts(0, 0, -2, 1, -1, 0, -1, 5));
        send_query(make_pts(0, 0, 10, 0, 20, -5, 20, 5));
        send_query(make_pts(-8388608, -8388608, 8388607, 8388607,
                            -8388608, 8388607, 8388607, -8388608));
        send_query(make_pts(0, 0, 1, 0, 0, 0, 1, 1000000));
        send_query(make_pts(0, 0, 1, 1, 8388600, 0, 8388607, 1));
        send_query(make_pts(0, 0, 1, 1, -8388600, 0, -8388607, 1));
        send_query(make_pts(0, 0, 1, 1, 0, 8388607, 1, 8388607));
        send_query(make_pts(0, 0, 0, 1, 0, 0, 8388607, 1));
        send_query(make_pts(8388607, 8388607, -8388608, -8388608,
                            -8388608, 8388607, 8388607, 8388607));
        send_query(make_pts(-1, -1, -1, -1, -1, -1, -1, -1));
        send_query(make_pts(8388607, -8388608, -8388608, 8388607, 0, 0, 1, 3));
        send_query(make_pts(1, 0, 0, 1, 0, 0, 1, 1));
    endtask

    // Random queries: half crafted to cross at a lattice point (some made parallel), the rest free.
    task automatic test_random(int unsigned count);
        sint_pkg::pts_t   p;
        sint_pkg::coord_t cx;
        sint_pkg::coord_t cy;
        int               dx;
        int               dy;
        for (int unsigned i = 0; i < count; i++)
        begin
            p = make_pts(0, 0, 0, 0, 0, 0, 0, 0);
            p.x1 = rand_coord(); p.y1 = rand_coord(); p.x2 = rand_coord(); p.y2 = rand_coord();
            p.x3 = rand_coord(); p.y3 = rand_coord(); p.x4 = rand_coord(); p.y4 = rand_coord();
            if ($urandom_range(0, 1) == 0)
            begin
                // Put the crossing on the first segment's line through a known point.
                cx = sint_pkg::coord_t'(int'($urandom_range(0, 200)) - 100);
                cy = sint_pkg::coord_t'(int'($urandom_range(0, 200)) - 100);
                dx = int'($urandom_range(0, 20)) - 10;
                dy = int'($urandom_range(0, 20)) - 10;
                p.x1 = cx - sint_pkg::coord_t'(dx); p.y1 = cy - sint_pkg::coord_t'(dy);
                p.x2 = cx + sint_pkg::coord_t'(dx * int'($urandom_range(0, 3)));
                p.y2 = cy + sint_pkg::coord_t'(dy * int'($urandom_range(0, 3)));
                p.x3 = cx + sint_pkg::coord_t'(int'($urandom_range(0, 20)) - 10);
                p.y3 = cy + sint_pkg::coord_t'(int'($urandom_range(0, 20)) - 10);
                p.x4 = cx; p.y4 = cy;
                if ($urandom_range(0, 7) == 0)
                begin
                    p.x4 = p.x3 + (p.x2 - p.x1);
                    p.y4 = p.y3 + (p.y2 - p.y1);
                end
            end
            send_query(p);
        end
    endtask

    // Back-to-back queries with no sender gaps, to fill the pipeline.
    task automatic test_burst(int unsigned count);
        sint_pkg::pts_t p;
        for (int unsigned i = 0; i < count; i++)
        begin
            p.x1 = rand_coord(); p.y1 = rand_coord(); p.x2 = rand_coord(); p.y2 = rand_coord();
            p.x3 = rand_coord(); p.y3 = rand_coord(); p.x4 = rand_coord(); p.y4 = rand_coord();
            send_query(p, 1'b0);
        end
    endtask

    // Receiver: checks each accepted transaction, then waits randomly if stalls are on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    $error("result transaction with no query outstanding");
                    errors++;
                end
                else
                begin
                    crossing_t e;
                    e = expected_crossings.pop_front();
                    if (m_tuser !== e.parallel)
                    begin
                        $error("parallel: expected %0d, actual %0d", e.parallel, m_tuser);
                        errors++;
                    end
                    if ($signed(m_tdata[sint_pkg::COORD_BITS-1:0]) !== e.cross_x)
                    begin
                        $error("cross_x: expected %0d, actual %0d", e.cross_x,
                               $signed(m_tdata[sint_pkg::COORD_BITS-1:0]));
                        errors++;
                    end
                    if ($signed(m_tdata[2*sint_pkg::COORD_BITS-1:sint_pkg::COORD_BITS])
                        !== e.cross_y)
                    begin
                        $error("cross_y: expected %0d, actual %0d", e.cross_y,
                               $signed(m_tdata[2*sint_pkg::COORD_BITS-1:sint_pkg::COORD_BITS]));
                        errors++;
                    end
                    if (m_tdata[2*sint_pkg::COORD_BITS] !== e.on_first)
                    begin
                        $error("on_first_segment: expected %0d, actual %0d", e.on_first,
                               m_tdata[2*sint_pkg::COORD_BITS]);
                        errors++;
                    end
                    crossings_checked++;
                    if (e.parallel)
                        parallel_seen++;
                    if (e.on_first)
                        on_segment_seen++;
                end
                // Draw the wait before the next transaction, none during open stretches.
                sink_wait = sink_stall_enable ? $urandom_range(0, 15) : 0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait = sink_wait - 1;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    // Stimulus sequence.
    initial
    begin
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        errors            = 0;
        queries_sent      = 0;
        crossings_checked = 0;
        parallel_seen     = 0;
        on_segment_seen   = 0;
        sink_stall_enable = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_results();
        test_random(500);
        sink_stall_enable = 1'b0;
        test_burst(200);
        drain_results();
        sink_stall_enable = 1'b1;
        test_random(300);
        test_burst(130);
        drain_results();
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d of %0d queries: %0d parallel, %0d on the first segment.",
                 crossings_checked, queries_sent, parallel_seen, on_segment_seen);
        if (errors == 0 && expected_crossings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
